// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk_sig, rstn_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error(msg);

// Implication form of the above.
`define ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons, msg) \
    `ASSERT_CLK(label, clk_sig, rstn_sig, (ante) |-> (cons), msg)

`endif

// File: sv/sit_pkg.sv
// Package for the symbol interning table: constants, codes, state type, helpers.
`default_nettype none
package sit_pkg;
    localparam int TABLE_ENTRIES_DEF  = 256;
    localparam int MAX_NAME_CHARS_DEF = 32;
    localparam int CFG_W              = 6;
    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 6'd32;
    localparam int OUT_W              = 8;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_0          = 8'h30;
    localparam logic [7:0] CH_9          = 8'h39;
    localparam logic [7:0] CH_LA         = 8'h61;
    localparam logic [7:0] CH_LZ         = 8'h7A;
    localparam logic [7:0] CH_UA         = 8'h41;
    localparam logic [7:0] CH_UZ         = 8'h5A;

    localparam logic [1:0] STAT_FOUND = 2'd0;
    localparam logic [1:0] STAT_NEW   = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_MISS,
        S_UPD,
        S_COPY
    } state_t;

    function automatic logic is_digit_char(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_symbol_char(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
            || is_digit_char(c) || (c == CH_UNDERSCORE) || (c == CH_STAR)
            || (c == CH_HASH);
    endfunction
endpackage
`default_nettype wire

// File: sv/symbol_interning_table_core.sv
// Top level of the symbol interning table: name capture, scan sequencer, stores.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  in      | in  | in_valid/in_stall  | char_code, last_char
//  out     | out | out_valid/out_stall| symbol_id, sorted_rank, status
//  cfg     | in  | wr_en              | wr_data (max_symbol_length)
//
// Characters transfer one per cycle. A last character starts the search:
// each stored entry above entry 0 is compared character by character through the one
// byte comparator and the key character RAM port; a miss then sweeps the
// stored ranks to move up those at or above the new rank, and copies the kept
// characters into the stores. Input stalls during the search and while a result waits.
// Reset sets the entry count to one, reserving entry 0 for the empty name; no clearing pass.
`default_nettype none
module symbol_interning_table_core #(
    parameter int TABLE_ENTRIES  = sit_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_NAME_CHARS = sit_pkg::MAX_NAME_CHARS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [7:0]               char_code,
    input  wire logic                     last_char,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [sit_pkg::OUT_W-1:0]     symbol_id,
    output logic [sit_pkg::OUT_W-1:0]     sorted_rank,
    output logic [1:0]                    status,
    input  wire logic                     wr_en,
    input  wire logic [sit_pkg::CFG_W-1:0] wr_data
);
    localparam int IDW    = $clog2(TABLE_ENTRIES);
    localparam int LEN_W  = $clog2(MAX_NAME_CHARS + 1);
    localparam int JW     = (MAX_NAME_CHARS > 1) ? $clog2(MAX_NAME_CHARS) : 1;
    localparam int CDEPTH = TABLE_ENTRIES * MAX_NAME_CHARS;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

    sit_pkg::state_t state_reg, state_next;
    logic [IDW-1:0]   idx_reg, idx_next;
    logic [LEN_W-1:0] j_reg, j_next;
    logic [IDW-1:0]   below_reg, below_next;
    logic [IDW:0]     count_reg, count_next;
    logic [LEN_W-1:0] name_len_reg, name_len_next;
    logic             stopped_reg, stopped_next;
    logic             lead_reg, lead_next;
    logic [7:0]       buf_reg [MAX_NAME_CHARS];
    logic             buf_we;
    logic [7:0]       buf_wdata;
    logic [sit_pkg::CFG_W-1:0] max_len_reg;
    logic             out_valid_reg, out_valid_next;
    logic [IDW-1:0]   out_id_reg, out_id_next;
    logic [IDW-1:0]   out_rank_reg, out_rank_next;
    logic [1:0]       out_status_reg, out_status_next;

    // store ports
    logic             char_we;
    logic [CAW-1:0]   char_waddr, char_raddr;
    logic [7:0]       char_wdata, char_rdata;
    logic             len_we;
    logic [LEN_W-1:0] len_rdata;
    logic             rank_we;
    logic [IDW-1:0]   rank_waddr, rank_wdata, rank_rdata;

    logic in_xfer, out_xfer;
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != sit_pkg::S_IDLE) || out_valid_reg;

    always_comb
    begin
        logic [LEN_W-1:0] limit;
        logic [LEN_W-1:0] n;
        logic [7:0]       stored_c, name_c;
        logic             done, equal, less, finish;

        state_next      = state_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        below_next      = below_reg;
        count_next      = count_reg;
        name_len_next   = name_len_reg;
        stopped_next    = stopped_reg;
        lead_next       = lead_reg;
        buf_we          = 1'b0;
        buf_wdata       = char_code;
        out_valid_next  = out_valid_reg && !out_xfer;
        out_id_next     = out_id_reg;
        out_rank_next   = out_rank_reg;
        out_status_next = out_status_reg;
        char_we         = 1'b0;
        char_wdata      = buf_reg[j_reg[JW-1:0]];
        len_we          = 1'b0;
        rank_we         = 1'b0;
        rank_waddr      = idx_reg;
        rank_wdata      = rank_rdata + 1'b1;
        finish          = 1'b0;
        done            = 1'b0;
        equal           = 1'b0;
        less            = 1'b0;
        stored_c        = char_rdata;
        name_c          = buf_reg[j_reg[JW-1:0]];

        // limit saturates at the buffer size
        if (32'(max_len_reg) > MAX_NAME_CHARS)
            limit = LEN_W'(MAX_NAME_CHARS);
        else
            limit = LEN_W'(max_len_reg);
        n = (len_rdata < name_len_reg) ? len_rdata : name_len_reg;

        unique case (state_reg)
            sit_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (!stopped_reg)
                    begin
                        if (name_len_reg == '0 && sit_pkg::is_digit_char(char_code))
                        begin
                            lead_next    = 1'b1;
                            stopped_next = 1'b1;
                        end
                        else if (sit_pkg::is_symbol_char(char_code) && name_len_reg < limit)
                        begin
                            buf_we        = 1'b1;
                            name_len_next = name_len_reg + 1'b1;
                        end
                        else
                        begin
                            stopped_next = 1'b1;
                        end
                    end
                    if (last_char)
                    begin
                        if (lead_next || name_len_next == '0)
                        begin
                            out_valid_next  = 1'b1;
                            out_id_next     = '0;
                            out_rank_next   = '0;
                            out_status_next = sit_pkg::STAT_EMPTY;
                            name_len_next   = '0;
                            stopped_next    = 1'b0;
                            lead_next       = 1'b0;
                        end
                        else
                        begin
                            // entry 0 is empty and always sorts below
                            below_next = IDW'(1);
                            idx_next   = IDW'(1);
                            j_next     = '0;
                            state_next = (count_reg == (IDW+1)'(1)) ? sit_pkg::S_MISS
                                                                      : sit_pkg::S_CMP;
                        end
                    end
                end
            end

            sit_pkg::S_CMP:
            begin
                if (j_reg == n)
                begin
                    done  = 1'b1;
                    equal = (len_rdata == name_len_reg);
                    less  = (len_rdata < name_len_reg);
                end
                else if (stored_c != name_c)
                begin
                    done = 1'b1;
                    less = (stored_c < name_c);
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
                if (done)
                begin
                    if (equal)
                    begin
                        out_valid_next  = 1'b1;
                        out_id_next     = idx_reg;
                        out_rank_next   = rank_rdata;
                        out_status_next = sit_pkg::STAT_FOUND;
                        finish          = 1'b1;
                    end
                    else
                    begin
                        below_next = below_reg + IDW'(less);
                        j_next     = '0;
                        if ((IDW+1)'(idx_reg) == count_reg - 1'b1)
                            state_next = sit_pkg::S_MISS;
                        else
                            idx_next = idx_reg + 1'b1;
                    end
                end
            end

            sit_pkg::S_MISS:
            begin
                if (count_reg == (IDW+1)'(TABLE_ENTRIES))
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = '0;
                    out_rank_next   = '0;
                    out_status_next = sit_pkg::STAT_FULL;
                    finish          = 1'b1;
                end
                else if (count_reg > (IDW+1)'(1))
                begin
                    idx_next   = IDW'(1);
                    state_next = sit_pkg::S_UPD;
                end
                else
                begin
                    j_next     = '0;
                    state_next = sit_pkg::S_COPY;
                end
            end

            sit_pkg::S_UPD:
            begin
                // entries at or above the new rank move up by one
                rank_we = (rank_rdata >= below_reg);
                if ((IDW+1)'(idx_reg) == count_reg - 1'b1)
                begin
                    j_next     = '0;
                    state_next = sit_pkg::S_COPY;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            sit_pkg::S_COPY:
            begin
                char_we = 1'b1;
                if (j_reg == '0)
                begin
                    len_we     = 1'b1;
                    rank_we    = 1'b1;
                    rank_waddr = count_reg[IDW-1:0];
                    rank_wdata = below_reg;
                end
                if (j_reg == name_len_reg - 1'b1)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = count_reg[IDW-1:0];
                    out_rank_next   = below_reg;
                    out_status_next = sit_pkg::STAT_NEW;
                    count_next      = count_reg + 1'b1;
                    finish          = 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = sit_pkg::S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next    = sit_pkg::S_IDLE;
            name_len_next = '0;
            stopped_next  = 1'b0;
            lead_next     = 1'b0;
        end
    end

    // read addresses follow the next indices so data lines up with the registers
    assign char_raddr = CAW'(idx_next * MAX_NAME_CHARS + j_next);
    assign char_waddr = CAW'(count_reg[IDW-1:0] * MAX_NAME_CHARS + j_reg);

    sit_ram #(.WIDTH(8), .DEPTH(CDEPTH)) u_key_chars (
        .clk     (clk),
        .wr_en   (char_we),
        .wr_addr (char_waddr),
        .wr_data (char_wdata),
        .rd_addr (char_raddr),
        .rd_data (char_rdata)
    );

    sit_ram #(.WIDTH(LEN_W), .DEPTH(TABLE_ENTRIES)) u_key_lengths (
        .clk     (clk),
        .wr_en   (len_we),
        .wr_addr (count_reg[IDW-1:0]),
        .wr_data (name_len_reg),
        .rd_addr (idx_next),
        .rd_data (len_rdata)
    );

    sit_ram #(.WIDTH(IDW), .DEPTH(TABLE_ENTRIES)) u_rank_by_id (
        .clk     (clk),
        .wr_en   (rank_we),
        .wr_addr (rank_waddr),
        .wr_data (rank_wdata),
        .rd_addr (idx_next),
        .rd_data (rank_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sit_pkg::S_IDLE;
            idx_reg       <= '0;
            j_reg         <= '0;
            below_reg     <= '0;
            count_reg     <= (IDW+1)'(1);
            name_len_reg  <= '0;
            stopped_reg   <= 1'b0;
            lead_reg      <= 1'b0;
            max_len_reg   <= sit_pkg::MAX_LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            j_reg         <= j_next;
            below_reg     <= below_next;
            count_reg     <= count_next;
            name_len_reg  <= name_len_next;
            stopped_reg   <= stopped_next;
            lead_reg      <= lead_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                max_len_reg <= wr_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_id_reg     <= out_id_next;
        out_rank_reg   <= out_rank_next;
        out_status_reg <= out_status_next;
        if (buf_we)
        begin
            buf_reg[name_len_reg[JW-1:0]] <= buf_wdata;
        end
    end

    assign out_valid   = out_valid_reg;
    assign symbol_id   = sit_pkg::OUT_W'(out_id_reg);
    assign sorted_rank = sit_pkg::OUT_W'(out_rank_reg);
    assign status      = out_status_reg;
endmodule
`default_nettype wire

// File: sv/sit_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// File: sv/sit_checker.sv
// Port-level checker for the symbol interning table, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module sit_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic [7:0]                char_code,
    input wire logic                      last_char,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic [sit_pkg::OUT_W-1:0] symbol_id,
    input wire logic [sit_pkg::OUT_W-1:0] sorted_rank,
    input wire logic [1:0]                status,
    input wire logic                      wr_en,
    input wire logic [sit_pkg::CFG_W-1:0] wr_data
);
    `ASSERT_IMPL(a_empty_is_null, clk, rst_n, out_valid && status == sit_pkg::STAT_EMPTY, symbol_id == '0 && sorted_rank == '0, "empty name not mapped to null")
    `ASSERT_IMPL(a_full_is_null, clk, rst_n, out_valid && status == sit_pkg::STAT_FULL, symbol_id == '0 && sorted_rank == '0, "full table result not null")
    `ASSERT_CLK(a_busy_after_last, clk, rst_n, (in_valid && !in_stall && last_char) |=> in_stall, "input not held off after last character")
    `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(symbol_id) && $stable(status)), "stalled result changed")
endmodule

bind symbol_interning_table_core sit_checker u_sit_checker (.*);
`default_nettype wire

// File: bench/tb_symbol_interning_table_core.sv
// Testbench for the symbol interning table core: scoreboarded random and directed names.
`default_nettype none
module tb_symbol_interning_table_core;

    localparam int N_ENTRIES = 256;
    localparam int N_CHARS   = 32;
    localparam int IDLE_LIMIT = 200000;

    // Expected result of one completed name.
    typedef struct packed {
        logic [7:0] id;
        logic [7:0] rank;
        logic [1:0] stat;
    } intern_result_t;

    // Scoreboard: shadow symbol table plus queue of pending results.
    class intern_scoreboard;
        logic [7:0]     names [N_ENTRIES][N_CHARS];
        int             lens [N_ENTRIES];
        int             ranks [N_ENTRIES];
        int             count;
        logic [7:0]     buf_chars [N_CHARS];
        int             buf_len;
        bit             stopped;
        bit             lead_digit;
        int             max_len;
        intern_result_t pending[$];
        int             errors;
        int             n_found, n_new, n_empty, n_full;

        function void clear();
            count = 1;
            lens[0] = 0;
            ranks[0] = 0;
            buf_len = 0;
            stopped = 0;
            lead_digit = 0;
            max_len = 32;
            errors = 0;
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        endtask

        function bit legal_char(logic [7:0] c);
            return (c >= sit_pkg::CH_LA && c <= sit_pkg::CH_LZ)
                || (c >= sit_pkg::CH_UA && c <= sit_pkg::CH_UZ)
                || (c >= sit_pkg::CH_0 && c <= sit_pkg::CH_9)
                || c == sit_pkg::CH_UNDERSCORE
                || c == sit_pkg::CH_STAR || c == sit_pkg::CH_HASH;
        endfunction

        // Order of stored entry against the buffered name: -1, 0 or 1.
        function int order_vs_buffer(int e);
            int n;
            n = lens[e] < buf_len ? lens[e] : buf_len;
            for (int i = 0; i < n; i++)
                if (names[e][i] != buf_chars[i])
                    return names[e][i] < buf_chars[i] ? -1 : 1;
            if (lens[e] == buf_len)
                return 0;
            return lens[e] < buf_len ? -1 : 1;
        endfunction

        function void note_char(logic [7:0] c, logic last);
            int lim;
            int below;
            int hit;
            intern_result_t r;
            lim = max_len > N_CHARS ? N_CHARS : max_len;
            if (!stopped)
            begin
                if (buf_len == 0 && c >= sit_pkg::CH_0 && c <= sit_pkg::CH_9)
                begin
                    lead_digit = 1;
                    stopped = 1;
                end
                else if (legal_char(c) && buf_len < lim)
                begin
                    buf_chars[buf_len] = c;
                    buf_len++;
                end
                else
                    stopped = 1;
            end
            if (!last)
                return;
            r = '{id: 0, rank: 0, stat: sit_pkg::STAT_EMPTY};
            if (!lead_digit && buf_len != 0)
            begin
                below = 0;
                hit = -1;
                for (int e = 0; e < count; e++)
                begin
                    int o;
                    o = order_vs_buffer(e);
                    if (o == 0)
                    begin
                        hit = e;
                        break;
                    end
                    if (o < 0)
                        below++;
                end
                if (hit >= 0)
                    r = '{id: hit[7:0], rank: ranks[hit][7:0], stat: sit_pkg::STAT_FOUND};
                else if (count < N_ENTRIES)
                begin
                    for (int e = 0; e < count; e++)
                        if (ranks[e] >= below)
                            ranks[e]++;
                    ranks[count] = below;
                    lens[count] = buf_len;
                    for (int i = 0; i < buf_len; i++)
                        names[count][i] = buf_chars[i];
                    r = '{id: count[7:0], rank: below[7:0], stat: sit_pkg::STAT_NEW};
                    count++;
                end
                else
                    r.stat = sit_pkg::STAT_FULL;
            end
            case (r.stat)
                sit_pkg::STAT_FOUND: n_found++;
                sit_pkg::STAT_NEW:   n_new++;
                sit_pkg::STAT_EMPTY: n_empty++;
                default:             n_full++;
            endcase
            pending.push_back(r);
            buf_len = 0;
            stopped = 0;
            lead_digit = 0;
        endfunction

        task check_result(logic [7:0] id, logic [7:0] rank, logic [1:0] stat);
            intern_result_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing pending", 0, 0);
                return;
            end
            want = pending[0];
            pending.delete(0);
            if (id !== want.id)
                report_mismatch("symbol_id", id, want.id);
            if (rank !== want.rank)
                report_mismatch("sorted_rank", rank, want.rank);
            if (stat !== want.stat)
                report_mismatch("status", stat, want.stat);
        endtask
    endclass

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic [7:0] char_code = 0;
    logic       last_char = 0;
    logic       out_stall = 0;
    logic       wr_en = 0;
    logic [5:0] wr_data = 0;
    wire        in_stall;
    wire        out_valid;
    wire [7:0]  symbol_id;
    wire [7:0]  sorted_rank;
    wire [1:0]  status;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_off = 0;         // cycles of forced receiver stall still to run
    int  idle_cycles = 0;
    bit  finished = 0;

    intern_scoreboard names_sb;

    symbol_interning_table_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .char_code(char_code), .last_char(last_char),
        .out_valid(out_valid), .out_stall(out_stall),
        .symbol_id(symbol_id), .sorted_rank(sorted_rank), .status(status),
        .wr_en(wr_en), .wr_data(wr_data)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                names_sb.check_result(symbol_id, sorted_rank, status);
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_stall <= 1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT && !finished)
        begin
            $display("watchdog expired");
            $display("symbol_interning_table_core test failed");
            $finish;
        end
    end

    // One character transfer, with optional random idle beforehand.
    task automatic send_char(logic [7:0] c, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid  <= 1;
        char_code <= c;
        last_char <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        names_sb.note_char(c, last);
    endtask

    task automatic send_name(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    // Drain pending results, then let the search engine settle.
    task automatic wait_quiet();
        in_valid <= 0;
        @(posedge clk);
        while (names_sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_max_len(logic [5:0] v);
        wait_quiet();
        wr_en   <= 1;
        wr_data <= v;
        @(posedge clk);
        wr_en <= 0;
        names_sb.max_len = v;
        @(posedge clk);
    endtask

    function automatic logic [7:0] rand_sym_char();
        case ($urandom_range(9))
            0:       return sit_pkg::CH_UNDERSCORE;
            1:       return sit_pkg::CH_STAR;
            2:       return sit_pkg::CH_HASH;
            3:       return 8'(sit_pkg::CH_0 + $urandom_range(9));
            4, 5:    return 8'(sit_pkg::CH_UA + $urandom_range(3));
            default: return 8'(sit_pkg::CH_LA + $urandom_range(3));
        endcase
    endfunction

    // Random name: mostly short symbol-char names from a small alphabet
    // so repeats hit; some noise bytes and leading digits.
    task automatic send_random_name();
        int n;
        logic [7:0] c;
        n = ($urandom_range(19) == 0) ? $urandom_range(34, 40) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(15) == 0)
                c = 8'($urandom_range(255));
            else
                c = rand_sym_char();
            send_char(c, i == n - 1);
        end
    endtask

    initial
    begin
        names_sb = new();
        names_sb.clear();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Sender idles more rarely than the receiver.
        send_idle_pct = 22;
        recv_idle_pct = 85;

        // Directed: found/new/empty/leading digit/cut/prefix ordering.
        send_name("b");
        send_name("a");
        send_name("ab");
        send_name("a");
        send_name("Zz_*#9");
        send_name("7up");
        send_char(8'h00, 1);
        send_char(8'hFF, 1);
        send_name("ab-cd");
        send_name("ab cd");
        send_name("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghij");
        send_name("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdef");
        set_max_len(6'd0);
        send_name("x");
        set_max_len(6'd63);
        send_name("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefXYZ");
        set_max_len(6'd1);
        send_name("qrs");
        send_name("b");
        set_max_len(6'd32);

        for (int k = 0; k < 70; k++)
            send_random_name();

        // Long receiver hold-off with the sender still offering.
        hold_off = 400;
        for (int k = 0; k < 15; k++)
            send_random_name();
        wait_quiet();

        set_max_len(6'd3);
        send_idle_pct = 85;
        recv_idle_pct = 22;
        for (int k = 0; k < 55; k++)
            send_random_name();

        set_max_len(6'd32);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Fill the table to overflow with unique names.
        for (int k = 0; k < 260; k++)
        begin
            string s;
            s = $sformatf("n%0d", k);
            send_name(s);
        end
        for (int k = 0; k < 25; k++)
            send_random_name();

        wait_quiet();
        finished = 1;
        repeat (50) @(posedge clk);
        $display("Covered %0d found, %0d new, %0d empty/invalid, %0d table-full names",
                 names_sb.n_found, names_sb.n_new, names_sb.n_empty, names_sb.n_full);
        $display("with length limits 0, 1, 3, 32 and 63 and varied flow control.");
        if (names_sb.errors == 0 && names_sb.pending.size() == 0)
            $display("symbol_interning_table_core test passed");
        else
            $display("symbol_interning_table_core test failed");
        $finish;
    end
endmodule
`default_nettype wire
